### rtl/pfrf_pkg.sv
// shared types, constants and mask function for the page framebuffer rectangle fill
package pfrf_pkg;

	typedef enum logic [1:0] {
		OP_FILL  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [6:0] left_column;
		logic [5:0] top_row;
		logic [6:0] right_column;
		logic [5:0] bottom_row;
		logic       color_black;
		logic [2:0] page_index;
		logic [7:0] byte_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       status;
	} rsp_t;

	localparam int         PAGE_ROWS = 8;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	// rows of one page covered by the inclusive span top..bottom
	function automatic logic [7:0] page_mask(input logic [2:0] page, input logic [5:0] top,
			input logic [5:0] bottom);
		logic [5:0] base;
		logic [5:0] lo_full;
		logic [5:0] hi_full;
		logic [2:0] lo;
		logic [2:0] hi;
		base    = {page, 3'b000};
		lo_full = (top > base) ? top - base : 6'd0;
		hi_full = (bottom < base + 6'd7) ? bottom - base : 6'd7;
		lo      = lo_full[2:0];
		hi      = hi_full[2:0];
		return (BYTE_ONES << lo) & (BYTE_ONES >> (3'd7 - hi));
	endfunction

endpackage

### rtl/pfrf_stream_if.sv
// valid/ready channel carrying one word of a given payload type
interface pfrf_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/page_framebuffer_rect_fill_top.sv
// page framebuffer with rectangle fill and byte access over a single-port-style store
//
// channel  dir  word    contents
// cmd      in   cmd_t   operation, rectangle corners, color, page, byte
// rsp      out  rsp_t   read byte, status
//
// after reset a clearing pass writes zero to every byte of the DISPLAY_WIDTH * pages store,
// with cmd.ready low until it ends
// one command at a time; a fill writes each byte of a full page directly and
// updates each byte of a partial page by read-modify-write through the registered
// store read
// a finished word waits in the rsp register while the next command is taken
module page_framebuffer_rect_fill_top import pfrf_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	pfrf_stream_if.sink   cmd,
	pfrf_stream_if.source rsp
);

	localparam int         PAGE_COUNT = (DISPLAY_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int         DEPTH      = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int         AW         = $clog2(DEPTH);
	localparam logic [6:0] COL_LAST   = 7'(DISPLAY_WIDTH - 1);
	localparam logic [5:0] ROW_LAST   = 6'(DISPLAY_HEIGHT - 1);
	localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_MODIFY,
		ST_RWAIT,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	cmd_t          cmd_q;
	logic [6:0]    x1_q;
	logic [5:0]    y1_q;
	logic [2:0]    page_q;
	logic [2:0]    p1_q;
	logic [6:0]    col_q;
	logic          status_q;
	logic [7:0]    rd_q;
	rsp_t          out_q;
	logic          out_valid_q;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    mem_rdata_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic          fill_inverted;
	logic          fill_outside;
	logic [6:0]    x1_clip;
	logic [5:0]    y1_clip;
	logic          byte_inside;
	logic [AW-1:0] byte_addr;
	logic [AW-1:0] walk_addr;
	logic [7:0]    walk_mask;
	logic          mask_full;
	logic [7:0]    fill_byte;
	logic [7:0]    mod_byte;
	logic          col_end;
	logic          page_end;

	assign fill_inverted = (cmd_q.right_column < cmd_q.left_column) ||
		(cmd_q.bottom_row < cmd_q.top_row);
	assign fill_outside  = (32'(cmd_q.left_column) >= DISPLAY_WIDTH) ||
		(32'(cmd_q.top_row) >= DISPLAY_HEIGHT);
	assign x1_clip = (32'(cmd_q.right_column) >= DISPLAY_WIDTH) ? COL_LAST : cmd_q.right_column;
	assign y1_clip = (32'(cmd_q.bottom_row) >= DISPLAY_HEIGHT) ? ROW_LAST : cmd_q.bottom_row;
	assign byte_inside = (32'(cmd_q.left_column) < DISPLAY_WIDTH) &&
		(32'(cmd_q.page_index) < PAGE_COUNT);
	assign byte_addr = AW'(32'(cmd_q.page_index) * DISPLAY_WIDTH + 32'(cmd_q.left_column));
	assign walk_addr = AW'(32'(page_q) * DISPLAY_WIDTH + 32'(col_q));
	assign walk_mask = page_mask(page_q, cmd_q.top_row, y1_q);
	assign mask_full = (walk_mask == BYTE_ONES);
	assign fill_byte = cmd_q.color_black ? BYTE_ONES : 8'h00;
	assign mod_byte  = cmd_q.color_black ? (mem_rdata_q | walk_mask) : (mem_rdata_q & ~walk_mask);
	assign col_end   = (col_q == x1_q);
	assign page_end  = (page_q == p1_q);

	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = walk_addr;
		mem_wdata = fill_byte;
		mem_re    = 1'b0;
		mem_raddr = walk_addr;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'h00;
			end
			ST_START: begin
				mem_waddr = byte_addr;
				mem_wdata = cmd_q.byte_value;
				mem_raddr = byte_addr;
				mem_we    = (cmd_q.operation == OP_WRITE) && byte_inside;
				mem_re    = (cmd_q.operation == OP_READ) && byte_inside;
			end
			ST_WALK: begin
				mem_we = mask_full;
				mem_re = !mask_full;
			end
			ST_MODIFY: begin
				mem_we    = 1'b1;
				mem_wdata = mod_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || rsp.ready))
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.valid) begin
						cmd_q   <= cmd.data;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					status_q <= 1'b0;
					rd_q     <= 8'h00;
					state_q  <= ST_DONE;
					unique case (cmd_q.operation)
						OP_FILL: begin
							if (fill_inverted) begin
								status_q <= 1'b1;
							end else if (!fill_outside) begin
								x1_q    <= x1_clip;
								y1_q    <= y1_clip;
								page_q  <= cmd_q.top_row[5:3];
								p1_q    <= y1_clip[5:3];
								col_q   <= cmd_q.left_column;
								state_q <= ST_WALK;
							end
						end
						OP_READ: begin
							if (byte_inside)
								state_q <= ST_RWAIT;
						end
						OP_WRITE, OP_NONE: begin
						end
					endcase
				end
				ST_WALK, ST_MODIFY: begin
					if (state_q == ST_WALK && !mask_full) begin
						state_q <= ST_MODIFY;
					end else if (!col_end) begin
						col_q   <= col_q + 1'b1;
						state_q <= ST_WALK;
					end else if (!page_end) begin
						page_q  <= page_q + 1'b1;
						col_q   <= cmd_q.left_column;
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RWAIT: begin
					rd_q    <= mem_rdata_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_q.read_byte <= rd_q;
						out_q.status    <= status_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/pfrf_checker.sv
// port-level checks for the page framebuffer rectangle fill, bound to the top level
module pfrf_checker import pfrf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("rsp word changed while stalled");

	// error status never comes with read data
	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status |-> rsp_data.read_byte == 8'h00)
		else $error("error status with nonzero read byte");

	// one command in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd taken while previous command busy");

	// no response word right after a command is taken
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !$rose(rsp_valid))
		else $error("rsp word appeared one cycle after cmd");

endmodule

bind page_framebuffer_rect_fill_top pfrf_checker u_pfrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
